[rtl/core/hap_pkg.sv]
// Shared constants and helpers for the Hammer-Aitoff projection pipeline.
package hap_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int LON_W = 17;
    localparam int LAT_W = 16;

    // Angles inside the pipeline are degrees with 16 fraction bits.
    localparam int ANG_W = 27;
    localparam int CORDIC_STEPS = 18;
    // CORDIC vector in Q30 with headroom for the gain overshoot.
    localparam int VEC_W = 33;
    localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Square root: 62-bit radicand, 31-bit root, 64-bit working remainder.
    localparam int SQ_IN_W = 62;
    localparam int SQ_OUT_W = 31;
    localparam int SQ_REM_W = 64;
    localparam int DEN_W = 32;

    // atan(2^-i) in degrees with 16 fraction bits.
    function automatic logic signed [ANG_W-1:0] atan_deg16(input int i);
        logic signed [ANG_W-1:0] a;
        unique case (i)
            0:  a = 27'sd2949120;
            1:  a = 27'sd1740967;
            2:  a = 27'sd919879;
            3:  a = 27'sd466945;
            4:  a = 27'sd234379;
            5:  a = 27'sd117304;
            6:  a = 27'sd58666;
            7:  a = 27'sd29335;
            8:  a = 27'sd14668;
            9:  a = 27'sd7334;
            10: a = 27'sd3667;
            11: a = 27'sd1833;
            12: a = 27'sd917;
            13: a = 27'sd458;
            14: a = 27'sd229;
            15: a = 27'sd115;
            16: a = 27'sd57;
            17: a = 27'sd29;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[rtl/core/hap_cordic.sv]
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
module hap_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [hap_pkg::ANG_W-1:0]   angle,
    output logic                               out_valid,
    output logic signed [hap_pkg::VEC_W-1:0]   sin_val,
    output logic signed [hap_pkg::VEC_W-1:0]   cos_val
);
    import hap_pkg::*;

    logic                    v_reg [CORDIC_STEPS];
    logic signed [VEC_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [VEC_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam logic signed [ANG_W-1:0] ATAN = atan_deg16(k);
        logic                    v_src;
        logic signed [VEC_W-1:0] x_src;
        logic signed [VEC_W-1:0] y_src;
        logic signed [ANG_W-1:0] z_src;
        logic signed [VEC_W-1:0] x_next;
        logic signed [VEC_W-1:0] y_next;
        logic signed [ANG_W-1:0] z_next;

        if (k == 0) begin : g_first
            assign v_src = in_valid;
            assign x_src = CORDIC_GAIN;
            assign y_src = '0;
            assign z_src = angle;
        end
        else begin : g_rest
            assign v_src = v_reg[k-1];
            assign x_src = x_reg[k-1];
            assign y_src = y_reg[k-1];
            assign z_src = z_reg[k-1];
        end

        always_comb
        begin
            if (z_src >= 0)
            begin
                x_next = x_src - (y_src >>> k);
                y_next = y_src + (x_src >>> k);
                z_next = z_src - ATAN;
            end
            else
            begin
                x_next = x_src + (y_src >>> k);
                y_next = y_src - (x_src >>> k);
                z_next = z_src + ATAN;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= x_next;
                y_reg[k] <= y_next;
                z_reg[k] <= z_next;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS-1];
    assign cos_val   = x_reg[CORDIC_STEPS-1];
    assign sin_val   = y_reg[CORDIC_STEPS-1];

endmodule

[rtl/core/hap_sqrt.sv]
// Pipelined floor square root, one root bit per stage, with a side payload.
module hap_sqrt #(
    parameter int SIDE_W = 94
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [hap_pkg::SQ_IN_W-1:0]    radicand,
    input  logic [SIDE_W-1:0]              side_in,
    output logic                           out_valid,
    output logic [hap_pkg::SQ_OUT_W-1:0]   root,
    output logic [SIDE_W-1:0]              side_out
);
    import hap_pkg::*;

    logic                v_reg    [SQ_OUT_W];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] r_reg    [SQ_OUT_W];
    logic [SIDE_W-1:0]   side_reg [SQ_OUT_W];

    for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_bit
        localparam int I = SQ_OUT_W - 1 - k;
        logic                v_src;
        logic [SQ_REM_W-1:0] rem_src;
        logic [SQ_OUT_W-1:0] r_src;
        logic [SIDE_W-1:0]   side_src;
        logic [SQ_REM_W-1:0] trial;
        logic [SQ_REM_W-1:0] rem_next;
        logic [SQ_OUT_W-1:0] r_next;

        if (k == 0) begin : g_first
            assign v_src    = in_valid;
            assign rem_src  = SQ_REM_W'(radicand);
            assign r_src    = '0;
            assign side_src = side_in;
        end
        else begin : g_rest
            assign v_src    = v_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign r_src    = r_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        // (R + 2^I)^2 - R^2 = R*2^(I+1) + 2^(2I)
        assign trial = (SQ_REM_W'(r_src) << (I + 1)) + (SQ_REM_W'(1) << (2 * I));

        always_comb
        begin
            if (rem_src >= trial)
            begin
                rem_next = rem_src - trial;
                r_next   = r_src | (SQ_OUT_W'(1) << I);
            end
            else
            begin
                rem_next = rem_src;
                r_next   = r_src;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                r_reg[k]    <= r_next;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = v_reg[SQ_OUT_W-1];
    assign root      = r_reg[SQ_OUT_W-1];
    assign side_out  = side_reg[SQ_OUT_W-1];

endmodule

[rtl/core/hap_div.sv]
// Pipelined restoring divider for a quotient of known width, one bit per stage.
module hap_div #(
    parameter int NUM_W = 48,
    parameter int QUO_W = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [NUM_W-1:0]              num,
    input  logic [hap_pkg::DEN_W-1:0]     den,
    input  logic                          neg_in,
    output logic                          out_valid,
    output logic [QUO_W-1:0]              quo,
    output logic                          neg_out
);
    import hap_pkg::*;

    logic             v_reg   [QUO_W];
    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] q_reg   [QUO_W];
    logic             neg_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_bit
        localparam int I = QUO_W - 1 - k;
        logic             v_src;
        logic [NUM_W-1:0] rem_src;
        logic [DEN_W-1:0] den_src;
        logic [QUO_W-1:0] q_src;
        logic             neg_src;
        logic [NUM_W-1:0] dsh;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] q_next;

        if (k == 0) begin : g_first
            assign v_src   = in_valid;
            assign rem_src = num;
            assign den_src = den;
            assign q_src   = '0;
            assign neg_src = neg_in;
        end
        else begin : g_rest
            assign v_src   = v_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign q_src   = q_reg[k-1];
            assign neg_src = neg_reg[k-1];
        end

        assign dsh = NUM_W'(den_src) << I;

        always_comb
        begin
            if (rem_src >= dsh)
            begin
                rem_next = rem_src - dsh;
                q_next   = q_src | (QUO_W'(1) << I);
            end
            else
            begin
                rem_next = rem_src;
                q_next   = q_src;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_src;
                q_reg[k]   <= q_next;
                neg_reg[k] <= neg_src;
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign quo       = q_reg[QUO_W-1];
    assign neg_out   = neg_reg[QUO_W-1];

endmodule

[rtl/core/hammer_aitoff_projection.sv]
// Stages from request acceptance to result, in order:
// input clamp, 18 CORDIC stages, clamp, multiply, scale, 31 square-root stages,
// ANGLE_FRAC_BITS + 8 divider stages and the output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset clears only the valid bits; the data registers are not reset.
module hammer_aitoff_projection #(
    parameter int ANGLE_FRAC_BITS = hap_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [hap_pkg::LON_W-1:0]  longitude,
    input  logic signed [hap_pkg::LAT_W-1:0]  latitude,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hap_pkg::LON_W-1:0]  map_x,
    output logic signed [hap_pkg::LAT_W-1:0]  map_y
);
    import hap_pkg::*;

    localparam int SHIFT16 = 16 - ANGLE_FRAC_BITS;
    localparam int NX_W    = ANGLE_FRAC_BITS + 39;
    localparam int NUM_W   = ANGLE_FRAC_BITS + 40;
    localparam int QUO_W   = ANGLE_FRAC_BITS + 8;
    localparam logic signed [ANG_W-1:0] LON_LIM = ANG_W'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W-1:0] LAT_LIM = ANG_W'(90 << ANGLE_FRAC_BITS);
    localparam logic [QUO_W-1:0] X_LIM = QUO_W'(180 << ANGLE_FRAC_BITS);
    localparam logic [QUO_W-1:0] Y_LIM = QUO_W'(90 << ANGLE_FRAC_BITS);

    logic en;

    // Global advance: every stage moves unless a finished result is held.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Input clamp and scaling to degrees with 16 fraction bits.
    logic signed [ANG_W-1:0] lon_ext;
    logic signed [ANG_W-1:0] lat_ext;
    logic signed [ANG_W-1:0] lon_c;
    logic signed [ANG_W-1:0] lat_c;
    logic signed [ANG_W-1:0] lon16;
    logic signed [ANG_W-1:0] half_next;
    logic signed [ANG_W-1:0] lat16_next;
    logic signed [ANG_W-1:0] half_reg;
    logic signed [ANG_W-1:0] lat16_reg;
    logic                    va_reg;

    always_comb
    begin
        lon_ext = ANG_W'(longitude);
        lat_ext = ANG_W'(latitude);
        if (lon_ext > LON_LIM)
            lon_c = LON_LIM;
        else if (lon_ext < -LON_LIM)
            lon_c = -LON_LIM;
        else
            lon_c = lon_ext;
        if (lat_ext > LAT_LIM)
            lat_c = LAT_LIM;
        else if (lat_ext < -LAT_LIM)
            lat_c = -LAT_LIM;
        else
            lat_c = lat_ext;
        lon16 = lon_c <<< SHIFT16;
        // Halving truncates toward zero.
        half_next  = (lon16 + $signed(ANG_W'(lon16 < 0))) >>> 1;
        lat16_next = lat_c <<< SHIFT16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            half_reg  <= half_next;
            lat16_reg <= lat16_next;
        end
    end

    // Sine and cosine of latitude and half longitude.
    logic                    lat_valid;
    logic                    lon_valid;
    logic signed [VEC_W-1:0] sb_raw;
    logic signed [VEC_W-1:0] cb_raw;
    logic signed [VEC_W-1:0] sh_raw;
    logic signed [VEC_W-1:0] ch_raw;

    hap_cordic u_cordic_lat (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (va_reg),
        .angle    (lat16_reg),
        .out_valid(lat_valid),
        .sin_val  (sb_raw),
        .cos_val  (cb_raw)
    );

    hap_cordic u_cordic_lon (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (va_reg),
        .angle    (half_reg),
        .out_valid(lon_valid),
        .sin_val  (sh_raw),
        .cos_val  (ch_raw)
    );

    // Clamp the CORDIC outputs to the unit range.
    localparam logic signed [VEC_W-1:0] ONE_V = VEC_W'(ONE_Q30);

    logic [30:0]        cb_next;
    logic [30:0]        ch_next;
    logic signed [31:0] sb_next;
    logic signed [31:0] sh_next;
    logic [30:0]        cb_reg;
    logic [30:0]        ch_reg;
    logic signed [31:0] sb_reg;
    logic signed [31:0] sh_reg;
    logic               vb_reg;

    always_comb
    begin
        if (cb_raw < 0)
            cb_next = '0;
        else if (cb_raw > ONE_V)
            cb_next = ONE_Q30;
        else
            cb_next = cb_raw[30:0];
        if (ch_raw < 0)
            ch_next = '0;
        else if (ch_raw > ONE_V)
            ch_next = ONE_Q30;
        else
            ch_next = ch_raw[30:0];
        if (sb_raw > ONE_V)
            sb_next = 32'(ONE_V);
        else if (sb_raw < -ONE_V)
            sb_next = 32'(-ONE_V);
        else
            sb_next = 32'(sb_raw);
        if (sh_raw > ONE_V)
            sh_next = 32'(ONE_V);
        else if (sh_raw < -ONE_V)
            sh_next = 32'(-ONE_V);
        else
            sh_next = 32'(sh_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= lat_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cb_reg <= cb_next;
            ch_reg <= ch_next;
            sb_reg <= sb_next;
            sh_reg <= sh_next;
        end
    end

    // Q60 products of the Q30 cosines and sine.
    logic [61:0]        pcc_next;
    logic signed [63:0] pcs_next;
    logic [61:0]        pcc_reg;
    logic signed [63:0] pcs_reg;
    logic signed [31:0] sbc_reg;
    logic               vc_reg;

    assign pcc_next = 62'(cb_reg) * 62'(ch_reg);
    assign pcs_next = 64'($signed({1'b0, cb_reg})) * 64'(sh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcc_reg <= pcc_next;
            pcs_reg <= pcs_next;
            sbc_reg <= sb_reg;
        end
    end

    // Radicand and scaled numerators.
    logic [30:0]              p_val;
    logic signed [32:0]       q_val;
    logic [SQ_IN_W-1:0]       arg_next;
    logic signed [NX_W-1:0]   nx_next;
    logic signed [NX_W-1:0]   ny_next;
    logic [SQ_IN_W-1:0]       arg_reg;
    logic signed [NX_W-1:0]   nx_reg;
    logic signed [NX_W-1:0]   ny_reg;
    logic                     vd_reg;

    assign p_val    = pcc_reg[60:30];
    assign q_val    = $signed(pcs_reg[62:30]);
    assign arg_next = (SQ_IN_W'(ONE_Q30) + SQ_IN_W'(p_val)) << 30;
    assign nx_next  = (NX_W'(q_val) * NX_W'(180)) <<< ANGLE_FRAC_BITS;
    assign ny_next  = (NX_W'(sbc_reg) * NX_W'(90)) <<< ANGLE_FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (en)
            vd_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_reg <= arg_next;
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
        end
    end

    // Denominator z = sqrt(1 + cos(b)*cos(l/2)).
    logic                  sq_valid;
    logic [SQ_OUT_W-1:0]   sq_root;
    logic [2*NX_W-1:0]     sq_side;

    hap_sqrt #(
        .SIDE_W(2 * NX_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (vd_reg),
        .radicand (arg_reg),
        .side_in  ({nx_reg, ny_reg}),
        .out_valid(sq_valid),
        .root     (sq_root),
        .side_out (sq_side)
    );

    // Round to nearest: (2|n| + z) / (2z), sign applied afterward.
    logic [SQ_OUT_W-1:0]    zc;
    logic signed [NX_W-1:0] nx_s;
    logic signed [NX_W-1:0] ny_s;
    logic [NX_W-1:0]        nx_mag;
    logic [NX_W-1:0]        ny_mag;
    logic [DEN_W-1:0]       den;
    logic [NUM_W-1:0]       num_x;
    logic [NUM_W-1:0]       num_y;

    always_comb
    begin
        zc     = (sq_root < ONE_Q30) ? ONE_Q30 : sq_root;
        nx_s   = $signed(sq_side[2*NX_W-1:NX_W]);
        ny_s   = $signed(sq_side[NX_W-1:0]);
        nx_mag = (nx_s < 0) ? NX_W'(-nx_s) : NX_W'(nx_s);
        ny_mag = (ny_s < 0) ? NX_W'(-ny_s) : NX_W'(ny_s);
        den    = {zc, 1'b0};
        num_x  = (NUM_W'(nx_mag) << 1) + NUM_W'(zc);
        num_y  = (NUM_W'(ny_mag) << 1) + NUM_W'(zc);
    end

    logic             dx_valid;
    logic             dy_valid;
    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;
    logic             negx;
    logic             negy;

    hap_div #(
        .NUM_W(NUM_W),
        .QUO_W(QUO_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .num      (num_x),
        .den      (den),
        .neg_in   (nx_s < 0),
        .out_valid(dx_valid),
        .quo      (qx),
        .neg_out  (negx)
    );

    hap_div #(
        .NUM_W(NUM_W),
        .QUO_W(QUO_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .num      (num_y),
        .den      (den),
        .neg_in   (ny_s < 0),
        .out_valid(dy_valid),
        .quo      (qy),
        .neg_out  (negy)
    );

    // Clamp the magnitude, apply the sign, keep the field width.
    logic [QUO_W-1:0]       mx;
    logic [QUO_W-1:0]       my;
    logic signed [31:0]     xs;
    logic signed [31:0]     ys;
    logic signed [LON_W-1:0] map_x_next;
    logic signed [LAT_W-1:0] map_y_next;
    logic signed [LON_W-1:0] map_x_reg;
    logic signed [LAT_W-1:0] map_y_reg;
    logic                    out_valid_reg;

    always_comb
    begin
        mx = (qx > X_LIM) ? X_LIM : qx;
        my = (qy > Y_LIM) ? Y_LIM : qy;
        xs = negx ? -$signed(32'(mx)) : $signed(32'(mx));
        ys = negy ? -$signed(32'(my)) : $signed(32'(my));
        map_x_next = xs[LON_W-1:0];
        map_y_next = ys[LAT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dx_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            map_x_reg <= map_x_next;
            map_y_reg <= map_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign map_x     = map_x_reg;
    assign map_y     = map_y_reg;

    // The two CORDIC lanes and the two dividers must stay in lockstep.
    a_cordic_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        lat_valid == lon_valid)
        else $error("CORDIC lanes out of step");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dx_valid == dy_valid)
        else $error("divider lanes out of step");

    // The radicand is at least 2^60, so the root never falls below one.
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> (sq_root >= ONE_Q30))
        else $error("square root below one");

    // A held result must not be replaced while the pipeline is frozen.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(map_x) && $stable(map_y)))
        else $error("held result changed");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the Hammer-Aitoff projection pipeline.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hap_pkg::*;

    localparam int FRAC = ANGLE_FRAC_BITS_DEF;
    localparam int LATENCY = FRAC + 62;
    localparam longint ONE = 64'sd1 << 30;

    typedef struct packed {
        logic signed [LON_W-1:0] x;
        logic signed [LAT_W-1:0] y;
    } map_pos_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [LON_W-1:0] longitude = '0;
    logic signed [LAT_W-1:0] latitude = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [LON_W-1:0] map_x;
    logic signed [LAT_W-1:0] map_y;

    map_pos_t expected_pos[$];
    int errors = 0;
    int stall_mode = 0;

    hammer_aitoff_projection i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .longitude(longitude), .latitude(latitude),
        .out_valid(out_valid), .out_ready(out_ready),
        .map_x(map_x), .map_y(map_y)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Rotation-mode CORDIC; angle in degrees with 16 fraction bits, result in Q30.
    function automatic void rotate_unit(input longint ang, output longint s,
                                        output longint c);
        longint vx, vy, va, nx;
        vx = 652032874;
        vy = 0;
        va = ang;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (va >= 0)
            begin
                nx = vx - shr_floor(vy, i);
                vy = vy + shr_floor(vx, i);
                va -= atan_deg16(i);
            end
            else
            begin
                nx = vx + shr_floor(vy, i);
                vy = vy - shr_floor(vx, i);
                va += atan_deg16(i);
            end
            vx = nx;
        end
        c = vx;
        s = vy;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint div_round(longint n, longint d);
        if (n >= 0)
            return (2 * n + d) / (2 * d);
        return -((2 * (-n) + d) / (2 * d));
    endfunction

    function automatic map_pos_t project(logic signed [LON_W-1:0] lon_in,
                                         logic signed [LAT_W-1:0] lat_in);
        longint deg, lon, lat, sb, cb, sh, ch, p, den, xv, yv;
        map_pos_t r;
        deg = 64'sd1 << FRAC;
        lon = clip(longint'(lon_in), -180 * deg, 180 * deg);
        lat = clip(longint'(lat_in), -90 * deg, 90 * deg);
        rotate_unit(lat * (64'sd1 << (16 - FRAC)), sb, cb);
        rotate_unit((lon * (64'sd1 << (16 - FRAC))) / 2, sh, ch);
        cb = clip(cb, 0, ONE);
        ch = clip(ch, 0, ONE);
        sb = clip(sb, -ONE, ONE);
        sh = clip(sh, -ONE, ONE);
        p = shr_floor(cb * ch, 30);
        den = floor_sqrt(longint'(ONE + p) << 30);
        if (den < ONE)
            den = ONE;
        xv = clip(div_round(180 * deg * shr_floor(cb * sh, 30), den), -180 * deg, 180 * deg);
        yv = clip(div_round(90 * deg * sb, den), -90 * deg, 90 * deg);
        r.x = xv[LON_W-1:0];
        r.y = yv[LAT_W-1:0];
        return r;
    endfunction

    // Result checker; the stall pattern changes with stall_mode.
    always @(posedge clk)
    begin
        map_pos_t e;
        if (out_valid && out_ready)
        begin
            if (expected_pos.size() == 0)
            begin
                $error("unexpected result x=%0d y=%0d", map_x, map_y);
                errors++;
            end
            else
            begin
                e = expected_pos.pop_front();
                if (map_x !== e.x)
                begin
                    $error("map_x expected %0d got %0d", e.x, map_x);
                    errors++;
                end
                if (map_y !== e.y)
                begin
                    $error("map_y expected %0d got %0d", e.y, map_y);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(3) != 0);
            default: out_ready <= ($urandom_range(7) < 2);
        endcase
    end

    int burst_left = 0;

    // Sends one request; holds valid across back-to-back requests within a burst.
    task automatic send_request(input logic signed [LON_W-1:0] lon,
                                input logic signed [LAT_W-1:0] lat);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(3) == 0 ? 0 : $urandom_range(6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        longitude <= lon;
        latitude <= lat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_pos.insert(expected_pos.size(), project(lon, lat));
        @(negedge clk);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_pos.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_corners();
        logic signed [LON_W-1:0] lons[] = '{-46080, 46080, 0, 1, -1, 23040, -23040,
                                             -65536, 65535, 46081, -46081};
        logic signed [LAT_W-1:0] lats[] = '{-23040, 23040, 0, 1, -1, -32768, 32767,
                                             23041, -23041};
        stall_mode = 0;
        foreach (lons[i])
            send_request(lons[i], lats[i % lats.size()]);
        foreach (lats[i])
            send_request(46080, lats[i]);
        send_request(-46080, -23040);
        go_idle();
    endtask

    task automatic test_in_range(int n);
        for (int i = 0; i < n; i++)
            send_request(LON_W'($urandom_range(92160) - 46080),
                         LAT_W'($urandom_range(46080) - 23040));
    endtask

    task automatic test_any_bits(int n);
        for (int i = 0; i < n; i++)
            send_request(LON_W'($urandom()), LAT_W'($urandom()));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_corners();
        stall_mode = 1;
        test_in_range(500);
        // Sender holds off here until the pipeline drains.
        go_idle();
        stall_mode = 2;
        test_in_range(400);
        test_any_bits(150);
        stall_mode = 0;
        test_in_range(200);
        test_any_bits(80);
        go_idle();
        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0 && expected_pos.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
